@@ sv/poe_pkg.sv @@
`default_nettype none

package poe_pkg;

  localparam int WORD_BITS = 16;
  localparam int WORD_LOG2 = 4;
  localparam int ACC_W     = 32;
  localparam int OPND_W    = 16;
  localparam int DIV_STEPS = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_ALU,
    ST_WEND,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_DIV,
    AS_SIGN,
    AS_DONE
  } alu_state_t;

  typedef struct packed {
    logic               start;
    op_t                op;
    logic [ACC_W-1:0]   acc;
    logic [OPND_W-1:0]  operand;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic             dz;
    logic [ACC_W-1:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ sv/packed_operand_expression_unit_top.sv @@
// Packed operand expression unit.
// Input channel in_*: in_tuser = 0 carries an instruction in in_tdata[31:0],
// in_tuser = 1 carries a packed data word in in_tdata[47:32]. An instruction
// sets up a new expression and clears any expression in progress; it gives
// no result. Data words received while no expression is pending are dropped.
// Output channel out_*: one transaction after the last data word that the
// expression needs, with the value in out_tdata[31:0] and the divide-by-zero
// flag in out_tdata[32].
// A data word is unpacked one bit per cycle, pausing while the single shared
// ALU works on each add, subtract, multiply or divide completed in it; a
// divide by a nonzero value works out 32 quotient bits one per cycle, then a
// sign fix and a hand-back. The last word also passes through the result
// register. in_tready is low while a word is worked on.
// The result sits in a register, so the next instruction or word is taken
// while it waits; if a new result is ready before the receiver takes the old
// one, the unit holds until out_tready. Reset clears all expression state
// and drops any pending result.
`default_nettype none

module packed_operand_expression_unit_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] instruction, [47:32] data_word
  input  wire logic        in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] result, [32] div_by_zero, [39:33] zero
);

  poe_pkg::state_t state_r, state_nxt;

  logic [15:0]                 codes_r, codes_nxt;
  logic [3:0]                  count_r, count_nxt;
  logic [4:0]                  width_r, width_nxt;
  logic [3:0]                  words_left_r, words_left_nxt;
  logic [poe_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [3:0]                  index_r, index_nxt;
  logic [15:0]                 partial_r, partial_nxt;
  logic [4:0]                  pbits_r, pbits_nxt;
  logic                        div_err_r, div_err_nxt;
  logic [poe_pkg::WORD_BITS-1:0] word_r, word_nxt;
  logic [4:0]                  bitcnt_r, bitcnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [poe_pkg::ACC_W-1:0]   out_result_r, out_result_nxt;
  logic                        out_dz_r, out_dz_nxt;

  poe_pkg::alu_req_t alu_req;
  poe_pkg::alu_rsp_t alu_rsp;

  logic        in_fire;
  logic [31:0] inst;
  logic [3:0]  dec_n;
  logic [4:0]  dec_two_n;
  logic [31:0] dec_codes_sh;
  logic [15:0] dec_mask;
  logic [31:0] dec_width_sh;
  logic [4:0]  dec_width;
  logic [8:0]  dec_total;
  logic [8:0]  dec_words;
  logic        cur_bit;
  logic [15:0] pfull;
  logic [4:0]  pbits_inc;
  logic        operand_done;
  logic        operand_used;
  logic        launch;
  logic [3:0]  code_pos;
  logic [15:0] codes_shifted;
  logic        out_free;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Instruction decode.
  assign inst         = in_tdata[31:0];
  assign dec_n        = {1'b0, inst[31:29]} + 4'd1;
  assign dec_two_n    = {dec_n, 1'b0};
  assign dec_codes_sh = inst >> (5'd29 - dec_two_n);
  assign dec_mask     = 16'hFFFF >> (5'd16 - dec_two_n);
  assign dec_width_sh = inst >> (5'd25 - dec_two_n);
  assign dec_width    = {1'b0, dec_width_sh[3:0]} + 5'd1;
  assign dec_total    = 9'(({5'b0, dec_n} + 9'd1) * {4'b0, dec_width});
  assign dec_words    = (dec_total + 9'(poe_pkg::WORD_BITS - 1)) >> poe_pkg::WORD_LOG2;

  // Bit-serial unpacking of the current word.
  assign cur_bit      = word_r[poe_pkg::WORD_BITS-1];
  assign pfull        = {partial_r[14:0], cur_bit};
  assign pbits_inc    = pbits_r + 5'd1;
  assign operand_done = (pbits_inc >= width_r);
  assign operand_used = operand_done && ({1'b0, index_r} <= {1'b0, count_r} + 5'd1 - 5'd1);
  assign launch       = (state_r == poe_pkg::ST_BITS) && operand_used && (index_r != 4'd0);

  // The first operator sits in the highest pair.
  assign code_pos      = count_r - index_r;
  assign codes_shifted = codes_r >> {code_pos, 1'b0};

  assign alu_req.start   = launch;
  assign alu_req.op      = poe_pkg::op_t'(codes_shifted[1:0]);
  assign alu_req.acc     = acc_r;
  assign alu_req.operand = pfull;

  poe_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      poe_pkg::ST_IDLE: begin
        if (in_fire && in_tuser && words_left_r != 4'd0) begin
          state_nxt = poe_pkg::ST_BITS;
        end
      end
      poe_pkg::ST_BITS: begin
        if (launch) begin
          state_nxt = poe_pkg::ST_ALU;
        end else if (bitcnt_r == 5'd1) begin
          state_nxt = poe_pkg::ST_WEND;
        end
      end
      poe_pkg::ST_ALU: begin
        if (alu_rsp.done) begin
          state_nxt = (bitcnt_r == 5'd0) ? poe_pkg::ST_WEND : poe_pkg::ST_BITS;
        end
      end
      poe_pkg::ST_WEND: begin
        state_nxt = (words_left_r == 4'd1) ? poe_pkg::ST_DONE : poe_pkg::ST_IDLE;
      end
      poe_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = poe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = poe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == poe_pkg::ST_IDLE);
    codes_nxt      = codes_r;
    count_nxt      = count_r;
    width_nxt      = width_r;
    words_left_nxt = words_left_r;
    acc_nxt        = acc_r;
    index_nxt      = index_r;
    partial_nxt    = partial_r;
    pbits_nxt      = pbits_r;
    div_err_nxt    = div_err_r;
    word_nxt       = word_r;
    bitcnt_nxt     = bitcnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_result_nxt = out_result_r;
    out_dz_nxt     = out_dz_r;
    case (state_r)
      poe_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!in_tuser) begin
            codes_nxt      = dec_codes_sh[15:0] & dec_mask;
            count_nxt      = dec_n;
            width_nxt      = dec_width;
            words_left_nxt = dec_words[3:0];
            acc_nxt        = '0;
            index_nxt      = '0;
            partial_nxt    = '0;
            pbits_nxt      = '0;
            div_err_nxt    = 1'b0;
          end else if (words_left_r != 4'd0) begin
            word_nxt   = in_tdata[32 +: poe_pkg::WORD_BITS];
            bitcnt_nxt = 5'(poe_pkg::WORD_BITS);
          end
        end
      end
      poe_pkg::ST_BITS: begin
        word_nxt   = {word_r[poe_pkg::WORD_BITS-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r - 5'd1;
        if (operand_done) begin
          partial_nxt = '0;
          pbits_nxt   = '0;
          if (operand_used) begin
            index_nxt = index_r + 4'd1;
            if (index_r == 4'd0) begin
              acc_nxt = {16'b0, pfull};
            end
          end
        end else begin
          partial_nxt = pfull;
          pbits_nxt   = pbits_inc;
        end
      end
      poe_pkg::ST_ALU: begin
        if (alu_rsp.done) begin
          acc_nxt = alu_rsp.result;
          if (alu_rsp.dz) begin
            div_err_nxt = 1'b1;
          end
        end
      end
      poe_pkg::ST_WEND: begin
        words_left_nxt = words_left_r - 4'd1;
      end
      poe_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          out_dz_nxt     = div_err_r;
          index_nxt      = '0;
          partial_nxt    = '0;
          pbits_nxt      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= poe_pkg::ST_IDLE;
      codes_r      <= '0;
      count_r      <= '0;
      width_r      <= '0;
      words_left_r <= '0;
      acc_r        <= '0;
      index_r      <= '0;
      partial_r    <= '0;
      pbits_r      <= '0;
      div_err_r    <= 1'b0;
      bitcnt_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      codes_r      <= codes_nxt;
      count_r      <= count_nxt;
      width_r      <= width_nxt;
      words_left_r <= words_left_nxt;
      acc_r        <= acc_nxt;
      index_r      <= index_nxt;
      partial_r    <= partial_nxt;
      pbits_r      <= pbits_nxt;
      div_err_r    <= div_err_nxt;
      bitcnt_r     <= bitcnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    word_r       <= word_nxt;
    out_result_r <= out_result_nxt;
    out_dz_r     <= out_dz_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_dz_r, out_result_r};

`ifndef NO_ASSERTIONS
  a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == poe_pkg::ST_ALU)
    else $error("ALU finished while the sequencer was not waiting for it");

  a_partial_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == poe_pkg::ST_BITS || state_r == poe_pkg::ST_ALU) |->
      pbits_r < width_r)
    else $error("Partial operand holds more bits than the operand width");

  a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, index_r} <= {1'b0, count_r} + 5'd1)
    else $error("More operands taken than the expression has");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == poe_pkg::ST_DONE && out_free) |=>
      (out_valid_r && state_r == poe_pkg::ST_IDLE))
    else $error("Finished expression did not reach the output register");
`endif

endmodule

`default_nettype wire

@@ sv/poe_alu.sv @@
`default_nettype none

module poe_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire poe_pkg::alu_req_t req,
  output poe_pkg::alu_rsp_t      rsp
);

  poe_pkg::alu_state_t state_r, state_nxt;
  logic [poe_pkg::ACC_W-1:0]  result_r, result_nxt;
  logic                       dz_r, dz_nxt;
  logic                       neg_r, neg_nxt;
  logic [poe_pkg::ACC_W-1:0]  quo_r, quo_nxt;
  logic [poe_pkg::OPND_W:0]   rem_r, rem_nxt;
  logic [poe_pkg::OPND_W-1:0] div_r, div_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic [poe_pkg::OPND_W:0]   rem_sh;
  logic [poe_pkg::ACC_W-1:0]  quo_sh;
  logic [poe_pkg::ACC_W-1:0]  opnd_ext;

  assign opnd_ext = {{(poe_pkg::ACC_W - poe_pkg::OPND_W){1'b0}}, req.operand};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      poe_pkg::AS_IDLE: begin
        if (req.start) begin
          if (req.op == poe_pkg::OP_DIV && req.operand != '0) begin
            state_nxt = poe_pkg::AS_DIV;
          end else begin
            state_nxt = poe_pkg::AS_DONE;
          end
        end
      end
      poe_pkg::AS_DIV: begin
        if (cnt_r == 5'(poe_pkg::DIV_STEPS - 1)) begin
          state_nxt = poe_pkg::AS_SIGN;
        end
      end
      poe_pkg::AS_SIGN: state_nxt = poe_pkg::AS_DONE;
      poe_pkg::AS_DONE: state_nxt = poe_pkg::AS_IDLE;
      default:          state_nxt = poe_pkg::AS_IDLE;
    endcase
  end

  always_comb begin
    result_nxt = result_r;
    dz_nxt     = dz_r;
    neg_nxt    = neg_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    cnt_nxt    = cnt_r;
    rem_sh     = {rem_r[poe_pkg::OPND_W-1:0], quo_r[poe_pkg::ACC_W-1]};
    quo_sh     = {quo_r[poe_pkg::ACC_W-2:0], 1'b0};
    case (state_r)
      poe_pkg::AS_IDLE: begin
        if (req.start) begin
          dz_nxt = 1'b0;
          case (req.op)
            poe_pkg::OP_ADD: result_nxt = req.acc + opnd_ext;
            poe_pkg::OP_SUB: result_nxt = req.acc - opnd_ext;
            poe_pkg::OP_MUL: result_nxt = req.acc * opnd_ext;
            poe_pkg::OP_DIV: begin
              if (req.operand == '0) begin
                // Divide by zero keeps the running value and raises the flag.
                result_nxt = req.acc;
                dz_nxt     = 1'b1;
              end else begin
                neg_nxt = req.acc[poe_pkg::ACC_W-1];
                quo_nxt = req.acc[poe_pkg::ACC_W-1] ? (~req.acc + 1'b1) : req.acc;
                rem_nxt = '0;
                div_nxt = req.operand;
                cnt_nxt = '0;
              end
            end
            default: result_nxt = req.acc;
          endcase
        end
      end
      poe_pkg::AS_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = rem_sh - {1'b0, div_r};
          quo_nxt = quo_sh | {{(poe_pkg::ACC_W-1){1'b0}}, 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = quo_sh;
        end
        cnt_nxt = cnt_r + 5'd1;
      end
      poe_pkg::AS_SIGN: begin
        result_nxt = neg_r ? (~quo_r + 1'b1) : quo_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= poe_pkg::AS_IDLE;
      dz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dz_r    <= dz_nxt;
    end
    result_r <= result_nxt;
    neg_r    <= neg_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign rsp.done   = (state_r == poe_pkg::AS_DONE);
  assign rsp.dz     = dz_r;
  assign rsp.result = result_r;

endmodule

`default_nettype wire

@@ test/packed_operand_expression_unit_top_test.sv @@
module packed_operand_expression_unit_top_test;

  localparam logic FUNC_INSTR   = 1'b0;
  localparam logic FUNC_DATA    = 1'b1;
  localparam int   ITEM_TARGET  = 1500;
  localparam int   CYCLE_LIMIT  = 3_000_000;
  localparam int   SETTLE_LIMIT = 500;
  localparam int   IDLE_PCT     = 35;

  typedef struct {
    logic [31:0] value;
    logic        dz;
  } expr_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [31:0] instruction, [47:32] data_word
  logic        in_tuser;   // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;  // [31:0] result, [32] div_by_zero, [39:33] zero

  // Expression state mirrored from the unit.
  logic [15:0] op_codes;
  logic [3:0]  op_count;
  logic [4:0]  opnd_width;
  logic [3:0]  words_pending;
  logic [31:0] acc;
  logic [3:0]  opnd_idx;
  logic [15:0] partial;
  logic [4:0]  partial_cnt;
  logic        dz_flag;

  expr_result_t expected_results[$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  logic         no_idle = 1'b0;

  packed_operand_expression_unit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packed_operand_expression_unit_top_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  always @(posedge clk) begin
    expr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result value %h dz %b",
                                out_tdata[31:0], out_tdata[32]));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.value)
          note_mismatch($sformatf("result expected %h actual %h",
                                  want.value, out_tdata[31:0]));
        if (out_tdata[32] !== want.dz)
          note_mismatch($sformatf("div_by_zero expected %b actual %b",
                                  want.dz, out_tdata[32]));
      end
    end
  end

  function automatic void take_operand(logic [15:0] v);
    int           shift;
    poe_pkg::op_t op;
    logic         neg;
    logic [31:0]  mag;
    logic [31:0]  quot;
    if (opnd_idx > op_count) return;
    if (opnd_idx == 0) begin
      acc = {16'h0, v};
    end else begin
      shift = ((int'(op_count) - int'(opnd_idx)) * 2) & 15;
      op = poe_pkg::op_t'(2'((op_codes >> shift) & 16'h3));
      case (op)
        poe_pkg::OP_ADD: acc = acc + {16'h0, v};
        poe_pkg::OP_SUB: acc = acc - {16'h0, v};
        poe_pkg::OP_MUL: acc = acc * {16'h0, v};
        poe_pkg::OP_DIV: begin
          // A zero divisor only raises the flag; the accumulator keeps its value.
          if (v == 16'h0) begin
            dz_flag = 1'b1;
          end else begin
            neg  = acc[31];
            mag  = neg ? (32'h0 - acc) : acc;
            quot = mag / {16'h0, v};
            acc  = neg ? (32'h0 - quot) : quot;
          end
        end
        default: begin
        end
      endcase
    end
    opnd_idx++;
  endfunction

  // Returns 1 when the item had an effect, 0 for a data word with nothing pending.
  function automatic bit predict_item(logic func, logic [31:0] instr, logic [15:0] word);
    int n;
    int total;
    if (func == FUNC_INSTR) begin
      n             = int'(instr[31:29]) + 1;
      op_count      = 4'(n);
      op_codes      = 16'((instr >> (29 - 2 * n)) & ((32'd1 << (2 * n)) - 1));
      opnd_width    = 5'(((instr >> (25 - 2 * n)) & 32'hF) + 1);
      total         = (n + 1) * int'(opnd_width);
      words_pending = 4'((total + poe_pkg::WORD_BITS - 1) / poe_pkg::WORD_BITS);
      acc           = 32'h0;
      opnd_idx      = 4'h0;
      partial       = 16'h0;
      partial_cnt   = 5'h0;
      dz_flag       = 1'b0;
      return 1'b1;
    end
    if (words_pending == 0) return 1'b0;
    for (int b = poe_pkg::WORD_BITS - 1; b >= 0; b--) begin
      partial = {partial[14:0], word[b]};
      partial_cnt++;
      if (partial_cnt >= opnd_width) begin
        take_operand(partial);
        partial     = 16'h0;
        partial_cnt = 5'h0;
      end
    end
    words_pending--;
    if (words_pending == 0) begin
      expected_results.push_back('{value: acc, dz: dz_flag});
      opnd_idx    = 4'h0;
      partial     = 16'h0;
      partial_cnt = 5'h0;
    end
    return 1'b1;
  endfunction

  task automatic send_item(input logic func, input logic [31:0] instr,
                           input logic [15:0] word);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= (func == FUNC_INSTR) ? {16'($urandom), instr} : {word, 32'($urandom)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_item(func, instr, word)) items_sent++;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Sends the instruction and then the first words_to_send data words
  // (all of them when negative). Operands are packed MSB first, padding is random.
  task automatic send_expression(input int n, input logic [15:0] codes, input int width,
                                 input logic [15:0] opnds [9], input int words_to_send);
    logic [0:159] stream;
    logic [31:0]  instr;
    logic [15:0]  word;
    int           pos;
    int           words;
    int           count;
    for (int k = 0; k < 160; k++) stream[k] = 1'($urandom_range(1));
    pos = 0;
    for (int i = 0; i <= n; i++) begin
      for (int b = width - 1; b >= 0; b--) begin
        stream[pos] = opnds[i][b];
        pos++;
      end
    end
    words = (pos + poe_pkg::WORD_BITS - 1) / poe_pkg::WORD_BITS;
    instr = (32'(n - 1) << 29)
          | ((32'(codes) & ((32'd1 << (2 * n)) - 1)) << (29 - 2 * n))
          | (32'(width - 1) << (25 - 2 * n))
          | ($urandom & ((32'd1 << (25 - 2 * n)) - 1));
    send_item(FUNC_INSTR, instr, 16'($urandom));
    count = (words_to_send < 0) ? words : words_to_send;
    for (int w = 0; w < count; w++) begin
      for (int k = 0; k < poe_pkg::WORD_BITS; k++)
        word[poe_pkg::WORD_BITS - 1 - k] = stream[w * poe_pkg::WORD_BITS + k];
      send_item(FUNC_DATA, $urandom, word);
    end
  endtask

  task automatic test_field_extremes();
    // All-zero instruction: one add of two one-bit operands.
    send_item(FUNC_INSTR, 32'h0000_0000, 16'h0000);
    send_item(FUNC_DATA, 32'hFFFF_FFFF, 16'hFFFF);
    // All-one instruction: eight divides of nine 16-bit operands over nine words.
    send_item(FUNC_INSTR, 32'hFFFF_FFFF, 16'hFFFF);
    for (int w = 0; w < 9; w++) send_item(FUNC_DATA, 32'h0000_0000, 16'hFFFF);
  endtask

  task automatic test_each_operator();
    logic [15:0] opnds [9];
    // The subtract drives the value negative, the multiply wraps it back to a
    // positive value, and the divide then works on a positive dividend.
    opnds = '{16'h0010, 16'h0020, 16'hFFFF, 16'hFFFF, 16'h0007, 0, 0, 0, 0};
    send_expression(4, 16'({poe_pkg::OP_ADD, poe_pkg::OP_SUB, poe_pkg::OP_MUL,
                           poe_pkg::OP_DIV}), 16, opnds, -1);
  endtask

  task automatic test_div_by_zero_and_padding();
    logic [15:0] opnds [9];
    // Five-bit operands span the word boundary and leave random padding.
    opnds = '{16'd17, 16'd0, 16'd3, 16'd31, 0, 0, 0, 0, 0};
    send_expression(3, 16'({poe_pkg::OP_DIV, poe_pkg::OP_ADD, poe_pkg::OP_SUB}), 5,
                    opnds, -1);
  endtask

  task automatic test_idle_data_word();
    send_item(FUNC_DATA, $urandom, 16'($urandom));
  endtask

  task automatic test_instruction_while_busy();
    logic [15:0] opnds [9];
    opnds = '{16'h1234, 16'h00FF, 16'h0003, 16'h8000, 16'h0002, 16'h0001, 16'h0009,
              16'hABCD, 16'h0005};
    send_expression(8, 16'($urandom), 16, opnds, 1);
    opnds = '{16'd9, 16'd4, 16'd2, 0, 0, 0, 0, 0, 0};
    send_expression(2, 16'({poe_pkg::OP_MUL, poe_pkg::OP_SUB}), 12, opnds, -1);
  endtask

  task automatic random_expression();
    logic [15:0] opnds [9];
    int          n;
    int          width;
    int          words;
    int          mode;
    int          pick;
    n     = $urandom_range(8, 1);
    width = ($urandom_range(99) < 60) ? $urandom_range(6, 1) : $urandom_range(16, 1);
    for (int i = 0; i < 9; i++) begin
      pick = $urandom_range(9);
      opnds[i] = (pick == 0) ? 16'h0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
    end
    words = ((n + 1) * width + poe_pkg::WORD_BITS - 1) / poe_pkg::WORD_BITS;
    mode  = $urandom_range(99);
    if (mode < 8)
      send_item(FUNC_DATA, $urandom, 16'($urandom));
    else if (mode < 18)
      send_expression(n, 16'($urandom), width, opnds, $urandom_range(words - 1, 0));
    else
      send_expression(n, 16'($urandom), width, opnds, -1);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) random_expression();
    wait_for_drain();
  endtask

  task automatic test_random_expressions();
    int iter;
    iter = 0;
    while (items_sent < ITEM_TARGET) begin
      no_idle <= (iter >= 150 && iter < 230);
      if (iter % 250 == 249) wait_for_drain();
      random_expression();
      iter++;
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 48'h0;
    in_tuser  <= FUNC_INSTR;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_data_word();
    test_field_extremes();
    test_each_operator();
    test_div_by_zero_and_padding();
    test_idle_data_word();
    test_instruction_while_busy();
    test_drain_pause();
    test_random_expressions();

    wait_for_drain();
    repeat (SETTLE_LIMIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("packed_operand_expression_unit_top_test: PASS");
    end else begin
      $display("packed_operand_expression_unit_top_test: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/poe_pkg.sv
sv/poe_alu.sv
sv/packed_operand_expression_unit_top.sv
test/packed_operand_expression_unit_top_test.sv
